// ===== rtl/core/mrs_pkg.sv =====
// Package for the Modbus RTU slave frame handler.
// Function codes, exception codes, controller/datapath bundles, CRC step and reset tables.
// No dependencies.
package mrs_pkg;

	localparam logic [7:0] FC_RD_COILS = 8'd1;
	localparam logic [7:0] FC_RD_DISC  = 8'd2;
	localparam logic [7:0] FC_RD_HOLD  = 8'd3;
	localparam logic [7:0] FC_RD_INPUT = 8'd4;
	localparam logic [7:0] FC_WR_COIL  = 8'd5;
	localparam logic [7:0] FC_WR_REG   = 8'd6;
	localparam logic [7:0] FC_WR_COILS = 8'd15;
	localparam logic [7:0] FC_WR_REGS  = 8'd16;

	localparam logic [1:0] EXC_NONE  = 2'd0;
	localparam logic [1:0] EXC_FUNC  = 2'd1;
	localparam logic [1:0] EXC_ADDR  = 2'd2;
	localparam logic [1:0] EXC_VALUE = 2'd3;

	localparam logic [7:0]  EXC_FLAG       = 8'h80;
	localparam logic [15:0] MAX_READ_REGS  = 16'd125;
	localparam logic [15:0] MAX_READ_BITS  = 16'd2000;
	localparam logic [15:0] MAX_WRITE_REGS = 16'd123;
	localparam logic [15:0] MAX_WRITE_BITS = 16'd1968;
	localparam logic [7:0]  COIL_ON        = 8'hFF;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [15:0] DATA_OFFSET    = 16'd7;

	localparam logic [2:0] K_EXC     = 3'd0;
	localparam logic [2:0] K_RREG    = 3'd1;
	localparam logic [2:0] K_RBIT    = 3'd2;
	localparam logic [2:0] K_WSINGLE = 3'd3;
	localparam logic [2:0] K_WCOILS  = 3'd4;
	localparam logic [2:0] K_WREGS   = 3'd5;

	localparam logic [2:0] EM_HDR  = 3'd0;
	localparam logic [2:0] EM_REG  = 3'd1;
	localparam logic [2:0] EM_BIT  = 3'd2;
	localparam logic [2:0] EM_CRCL = 3'd3;
	localparam logic [2:0] EM_CRCH = 3'd4;

	localparam int MAX_BITS = 400;

	typedef struct packed {
		logic       rx_take;
		logic       decode;
		logic       wr_single;
		logic       rd_issue;
		logic       rd_lo;
		logic       cap_hi;
		logic       wr_coil;
		logic       wr_reg;
		logic       gather;
		logic       emit;
		logic [2:0] emit_sel;
		logic       frame_done;
	} mrs_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       hdr_last;
		logic       i_end;
		logic       bit_full;
		logic       out_free;
	} mrs_sts_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] reg_init(input int idx);
		logic [15:0] v;
		case (idx)
			0: v = 16'd0;      1: v = 16'd1111;   2: v = 16'd2222;   3: v = 16'd3333;
			4: v = 16'd4444;   5: v = 16'd5555;   6: v = 16'd6666;   7: v = 16'd7777;
			8: v = 16'd8888;   9: v = 16'd9999;   10: v = 16'd12345; 11: v = 16'd15432;
			12: v = 16'd15535; 13: v = 16'd10234; 14: v = 16'd19876; 15: v = 16'd13579;
			16: v = 16'd10293; 17: v = 16'd19827; 18: v = 16'd13456; 19: v = 16'd14567;
			20: v = 16'd21345; 21: v = 16'd22345; 22: v = 16'd24567; 23: v = 16'd25678;
			24: v = 16'd26789; 25: v = 16'd24680; 26: v = 16'd20394; 27: v = 16'd29384;
			default: v = 16'd26937;
		endcase
		return v;
	endfunction

	function automatic logic [MAX_BITS-1:0] bit_pattern(input logic [39:0] pat);
		logic [MAX_BITS-1:0] r;
		for (int b = 0; b < MAX_BITS / 8; b++) begin
			r[b*8 +: 8] = pat[(b % 5) * 8 +: 8];
		end
		return r;
	endfunction

	localparam logic [MAX_BITS-1:0] COIL_ALL = bit_pattern(40'hCC_55_AA_9C_49);
	localparam logic [MAX_BITS-1:0] DISC_ALL = bit_pattern(40'h69_AA_55_9A_46);

endpackage

// ===== rtl/core/mrs_if.sv =====
// Valid/ready channel interfaces for request and response bytes.
// No dependencies.
interface mrs_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_last;
	modport source (output valid, output rx_byte, output frame_last, input ready);
	modport sink (input valid, input rx_byte, input frame_last, output ready);
endinterface

interface mrs_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_last;
	modport source (output valid, output tx_byte, output tx_last, input ready);
	modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

// ===== rtl/core/mrs_ctrl.sv =====
// Sequencer for the Modbus RTU slave frame handler.
// Depends on mrs_pkg.
module mrs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	input  logic             rx_last,
	output logic             rx_ready,
	input  mrs_pkg::mrs_sts_t sts,
	output mrs_pkg::mrs_cmd_t cmd
);
	import mrs_pkg::*;

	localparam logic [3:0] S_RX     = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_WS     = 4'd2;
	localparam logic [3:0] S_WC_RD  = 4'd3;
	localparam logic [3:0] S_WC_DO  = 4'd4;
	localparam logic [3:0] S_WR_RDH = 4'd5;
	localparam logic [3:0] S_WR_RDL = 4'd6;
	localparam logic [3:0] S_WR_DO  = 4'd7;
	localparam logic [3:0] S_HDR    = 4'd8;
	localparam logic [3:0] S_RDREG  = 4'd9;
	localparam logic [3:0] S_GATH   = 4'd10;
	localparam logic [3:0] S_BITOUT = 4'd11;
	localparam logic [3:0] S_BITLST = 4'd12;
	localparam logic [3:0] S_CRCL   = 4'd13;
	localparam logic [3:0] S_CRCH   = 4'd14;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RX;
		end else begin
			state_q <= state_d;
		end
	end

	assign rx_ready = (state_q == S_RX);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_RX: begin
				if (rx_valid) begin
					cmd.rx_take = 1'b1;
					if (rx_last) state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				unique case (sts.kind)
					K_WSINGLE: state_d = S_WS;
					K_WCOILS:  state_d = S_WC_RD;
					K_WREGS:   state_d = S_WR_RDH;
					default:   state_d = S_HDR;
				endcase
			end
			S_WS: begin
				cmd.wr_single = 1'b1;
				state_d = S_HDR;
			end
			S_WC_RD: begin
				cmd.rd_issue = 1'b1;
				state_d = S_WC_DO;
			end
			S_WC_DO: begin
				cmd.wr_coil = 1'b1;
				state_d = sts.i_end ? S_HDR : S_WC_RD;
			end
			S_WR_RDH: begin
				cmd.rd_issue = 1'b1;
				state_d = S_WR_RDL;
			end
			S_WR_RDL: begin
				cmd.rd_issue = 1'b1;
				cmd.rd_lo = 1'b1;
				cmd.cap_hi = 1'b1;
				state_d = S_WR_DO;
			end
			S_WR_DO: begin
				cmd.wr_reg = 1'b1;
				state_d = sts.i_end ? S_HDR : S_WR_RDH;
			end
			S_HDR: begin
				cmd.emit_sel = EM_HDR;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.hdr_last) begin
						if (sts.kind == K_RREG) state_d = S_RDREG;
						else if (sts.kind == K_RBIT) state_d = S_GATH;
						else state_d = S_CRCL;
					end
				end
			end
			S_RDREG: begin
				cmd.emit_sel = EM_REG;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.i_end) state_d = S_CRCL;
				end
			end
			S_GATH: begin
				cmd.gather = 1'b1;
				if (sts.bit_full) state_d = sts.i_end ? S_BITLST : S_BITOUT;
			end
			S_BITOUT, S_BITLST: begin
				cmd.emit_sel = EM_BIT;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = (state_q == S_BITLST) ? S_CRCL : S_GATH;
				end
			end
			S_CRCL: begin
				cmd.emit_sel = EM_CRCL;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_CRCH;
				end
			end
			S_CRCH: begin
				cmd.emit_sel = EM_CRCH;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.frame_done = 1'b1;
					state_d = S_RX;
				end
			end
			default: state_d = S_RX;
		endcase
	end

endmodule

// ===== rtl/core/mrs_dp.sv =====
// Datapath: frame buffer, data stores, request decode, response bytes and CRC.
// Depends on mrs_pkg.
module mrs_dp #(
	parameter int REG_COUNT   = 16,
	parameter int BIT_COUNT   = 200,
	parameter int FRAME_BYTES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic [7:0]        rx_byte,
	input  mrs_pkg::mrs_cmd_t cmd,
	output mrs_pkg::mrs_sts_t sts,
	input  logic              tx_ready,
	output logic              tx_valid,
	output logic [7:0]        tx_byte,
	output logic              tx_last
);
	import mrs_pkg::*;

	localparam int AW  = $clog2(FRAME_BYTES);
	localparam int LW  = $clog2(FRAME_BYTES + 1);
	localparam int CW  = $clog2(BIT_COUNT + 2 * REG_COUNT + 8);
	localparam int PW  = $clog2(2 * BIT_COUNT + 8);
	localparam int BIW = $clog2(BIT_COUNT);
	localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam logic [BIT_COUNT-1:0] COIL_RST = COIL_ALL[BIT_COUNT-1:0];
	localparam logic [BIT_COUNT-1:0] DISC_VAL = DISC_ALL[BIT_COUNT-1:0];

	logic [7:0]           mem_q [FRAME_BYTES];
	logic [LW-1:0]        len_q;
	logic [7:0]           hdr_q [6];
	logic [7:0]           slave_q;
	logic [15:0]          holding_q [REG_COUNT];
	logic [BIT_COUNT-1:0] coil_q;
	logic [7:0]           rd_data_q;
	logic                 rd_ok_q;
	logic [7:0]           hi_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        limit_q;
	logic [7:0]           count_q;
	logic [2:0]           hx_q;
	logic [7:0]           shift_q;
	logic [15:0]          crc_q;
	logic                 tx_valid_q;
	logic [7:0]           tx_byte_q;
	logic                 tx_last_q;

	logic [7:0]    fc;
	logic [15:0]   start, qty, rd_addr;
	logic [16:0]   sum;
	logic [1:0]    exc;
	logic [2:0]    kind;
	logic [CW-1:0] qty_c, qty_r8;
	logic [PW-1:0] ptr;
	logic [RIW-1:0] rw_idx, rr_idx;
	logic [15:0]   rword;
	logic          bit_val;
	logic [7:0]    rd_byte, hdr_byte, emit_byte;

	assign fc    = hdr_q[1];
	assign start = {hdr_q[2], hdr_q[3]};
	assign qty   = {hdr_q[4], hdr_q[5]};
	assign sum   = {1'b0, start} + {1'b0, qty};
	assign qty_c = qty[CW-1:0];
	assign qty_r8 = (qty_c + CW'(7)) & ~CW'(7);

	always_comb begin
		exc = EXC_NONE;
		unique case (fc) inside
			FC_RD_HOLD, FC_RD_INPUT: begin
				if (qty == 16'd0 || qty > MAX_READ_REGS) exc = EXC_VALUE;
				else if (sum > 17'(REG_COUNT)) exc = EXC_ADDR;
			end
			FC_RD_COILS, FC_RD_DISC: begin
				if (qty == 16'd0 || qty > MAX_READ_BITS) exc = EXC_VALUE;
				else if (sum > 17'(BIT_COUNT)) exc = EXC_ADDR;
			end
			FC_WR_COIL: begin
				if (start >= 16'(BIT_COUNT)) exc = EXC_ADDR;
			end
			FC_WR_REG: begin
				if (start >= 16'(REG_COUNT)) exc = EXC_ADDR;
			end
			FC_WR_COILS: begin
				if (qty == 16'd0 || qty > MAX_WRITE_BITS) exc = EXC_VALUE;
				else if (sum > 17'(BIT_COUNT)) exc = EXC_ADDR;
			end
			FC_WR_REGS: begin
				if (qty == 16'd0 || qty > MAX_WRITE_REGS) exc = EXC_VALUE;
				else if (sum > 17'(REG_COUNT)) exc = EXC_ADDR;
			end
			default: exc = EXC_FUNC;
		endcase
	end

	always_comb begin
		if (exc != EXC_NONE) begin
			kind = K_EXC;
		end else begin
			unique case (fc) inside
				FC_RD_HOLD, FC_RD_INPUT: kind = K_RREG;
				FC_RD_COILS, FC_RD_DISC: kind = K_RBIT;
				FC_WR_COILS:             kind = K_WCOILS;
				FC_WR_REGS:              kind = K_WREGS;
				default:                 kind = K_WSINGLE;
			endcase
		end
	end

	assign ptr     = start[PW-1:0] + PW'(i_q);
	assign rw_idx  = RIW'(start[RIW-1:0] + RIW'(i_q));
	assign rr_idx  = RIW'(start[RIW-1:0] + RIW'(i_q >> 1));
	assign rword   = (fc == FC_RD_HOLD) ? holding_q[rr_idx] : reg_init(int'(rr_idx));
	assign bit_val = ({{(16-CW){1'b0}}, i_q} < qty) && (ptr < PW'(BIT_COUNT))
		&& ((fc == FC_RD_COILS) ? coil_q[ptr[BIW-1:0]] : DISC_VAL[ptr[BIW-1:0]]);
	assign rd_byte = rd_ok_q ? rd_data_q : 8'h00;
	assign rd_addr = (kind == K_WCOILS)
		? DATA_OFFSET + 16'(i_q >> 3)
		: DATA_OFFSET + 16'({i_q, 1'b0}) + {15'd0, cmd.rd_lo};

	always_comb begin
		hdr_byte = 8'h00;
		if (kind == K_EXC) begin
			case (hx_q)
				3'd0:    hdr_byte = hdr_q[0];
				3'd1:    hdr_byte = fc | EXC_FLAG;
				default: hdr_byte = {6'd0, exc};
			endcase
		end else if (kind == K_RREG || kind == K_RBIT) begin
			case (hx_q)
				3'd0:    hdr_byte = slave_q;
				3'd1:    hdr_byte = fc;
				default: hdr_byte = count_q;
			endcase
		end else begin
			case (hx_q)
				3'd0:    hdr_byte = slave_q;
				3'd1:    hdr_byte = hdr_q[1];
				3'd2:    hdr_byte = hdr_q[2];
				3'd3:    hdr_byte = hdr_q[3];
				3'd4:    hdr_byte = hdr_q[4];
				default: hdr_byte = hdr_q[5];
			endcase
		end
	end

	always_comb begin
		case (cmd.emit_sel)
			EM_HDR:  emit_byte = hdr_byte;
			EM_REG:  emit_byte = i_q[0] ? rword[7:0] : rword[15:8];
			EM_BIT:  emit_byte = shift_q;
			EM_CRCL: emit_byte = crc_q[7:0];
			default: emit_byte = crc_q[15:8];
		endcase
	end

	assign sts.kind     = kind;
	assign sts.hdr_last = (kind == K_EXC || kind == K_RREG || kind == K_RBIT)
		? (hx_q == 3'd2) : (hx_q == 3'd5);
	assign sts.i_end    = (i_q == limit_q);
	assign sts.bit_full = (i_q[2:0] == 3'd7);
	assign sts.out_free = !tx_valid_q || tx_ready;

	assign tx_valid = tx_valid_q;
	assign tx_byte  = tx_byte_q;
	assign tx_last  = tx_last_q;

	always_ff @(posedge clk) begin
		if (cmd.rx_take && len_q < LW'(FRAME_BYTES)) mem_q[len_q[AW-1:0]] <= rx_byte;
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_addr[AW-1:0]];
			rd_ok_q   <= rd_addr < 16'(len_q);
		end
		if (cmd.cap_hi) hi_q <= rd_byte;
		if (cmd.gather) shift_q <= {bit_val, shift_q[7:1]};
		if (cmd.emit) begin
			tx_byte_q <= emit_byte;
			tx_last_q <= (cmd.emit_sel == EM_CRCH);
		end
		if (cmd.decode) begin
			unique case (kind)
				K_RREG:  limit_q <= (qty_c << 1) - CW'(1);
				K_RBIT:  limit_q <= qty_r8 - CW'(1);
				default: limit_q <= qty_c - CW'(1);
			endcase
			count_q <= (kind == K_RREG) ? 8'(qty_c << 1) : 8'(qty_r8 >> 3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			slave_q    <= 8'd1;
			coil_q     <= COIL_RST;
			i_q        <= '0;
			hx_q       <= '0;
			crc_q      <= CRC_INIT;
			tx_valid_q <= 1'b0;
			for (int k = 0; k < 6; k++) hdr_q[k] <= 8'h00;
			for (int k = 0; k < REG_COUNT; k++) holding_q[k] <= reg_init(k);
		end else begin
			if (cfg_we) slave_q <= cfg_wdata;
			if (cmd.rx_take) begin
				if (len_q < LW'(FRAME_BYTES)) len_q <= len_q + LW'(1);
				if (len_q == '0) begin
					hdr_q[0] <= rx_byte;
					for (int k = 1; k < 6; k++) hdr_q[k] <= 8'h00;
				end
				for (int k = 1; k < 6; k++) begin
					if (len_q == LW'(k)) hdr_q[k] <= rx_byte;
				end
			end
			if (cmd.frame_done) len_q <= '0;
			if (cmd.decode) begin
				i_q   <= '0;
				hx_q  <= '0;
				crc_q <= CRC_INIT;
			end
			if (cmd.wr_single) begin
				if (fc == FC_WR_REG) begin
					holding_q[start[RIW-1:0]] <= qty;
				end else if (hdr_q[5] == 8'h00) begin
					if (hdr_q[4] == COIL_ON) coil_q[start[BIW-1:0]] <= 1'b1;
					else if (hdr_q[4] == 8'h00) coil_q[start[BIW-1:0]] <= 1'b0;
				end
			end
			if (cmd.wr_coil) begin
				coil_q[ptr[BIW-1:0]] <= rd_byte[i_q[2:0]];
				i_q <= i_q + CW'(1);
			end
			if (cmd.wr_reg) begin
				holding_q[rw_idx] <= {hi_q, rd_byte};
				i_q <= i_q + CW'(1);
			end
			if (cmd.gather) i_q <= i_q + CW'(1);
			if (cmd.emit) begin
				tx_valid_q <= 1'b1;
				if (cmd.emit_sel != EM_CRCL && cmd.emit_sel != EM_CRCH) begin
					crc_q <= crc_byte(crc_q, emit_byte);
				end
				if (cmd.emit_sel == EM_HDR) begin
					hx_q <= hx_q + 3'd1;
					if (sts.hdr_last) i_q <= '0;
				end
				if (cmd.emit_sel == EM_REG) i_q <= i_q + CW'(1);
			end else if (tx_ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/modbus_rtu_slave_frame_handler_top.sv =====
// Top level of the Modbus RTU slave frame handler.
// Depends on mrs_pkg, mrs_if, mrs_ctrl and mrs_dp.
//
// Usage:
//   rx carries request bytes (address byte first, CRC already checked and
//   removed); frame_last marks the final byte. Bytes are taken whenever
//   valid is high while the block is receiving.
//   tx carries the response bytes, ending with CRC low then CRC high;
//   tx_last marks the CRC high byte.
//   cfg_we/cfg_wdata write the slave address used in normal responses.
//   After the final request byte the block decodes it, then performs
//   writes: per coil a byte read and a write for code 15, per register
//   two byte reads and a write for code 16, one write for codes 5 and 6.
//   It then emits one response byte per cycle, except coil and discrete
//   reads, which gather eight bits per data byte before emitting it. A
//   new request is taken only after the CRC high byte is in the output
//   register. A stalled receiver holds the output register and the next
//   emit. Reset loads the stores' fixed tables, sets the slave address to
//   1 and empties the frame buffer; no clearing pass is needed.
module modbus_rtu_slave_frame_handler_top #(
	parameter int REG_COUNT   = 16,
	parameter int BIT_COUNT   = 200,
	parameter int FRAME_BYTES = 256
) (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [7:0] cfg_wdata,
	mrs_rx_if.sink    rx,
	mrs_tx_if.source  tx
);
	import mrs_pkg::*;

	mrs_cmd_t cmd;
	mrs_sts_t sts;

	mrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_last  (rx.frame_last),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mrs_dp #(
		.REG_COUNT   (REG_COUNT),
		.BIT_COUNT   (BIT_COUNT),
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.sts       (sts),
		.tx_ready  (tx.ready),
		.tx_valid  (tx.valid),
		.tx_byte   (tx.tx_byte),
		.tx_last   (tx.tx_last)
	);

endmodule
